// ===== design/hkm_pkg.sv =====
package hkm_pkg;
	localparam int TRIGGER_SLOTS = 16;
	localparam int HELD_KEYS = 8;
	localparam int SLOT_W = 4;
	localparam int HELD_W = 3;
	localparam int CNT_W = 4;

	localparam logic [1:0] ACT_PRESS = 2'd0;
	localparam logic [1:0] ACT_RELEASE = 2'd1;
	localparam logic [1:0] ACT_WRITE = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_FIND, ST_SHIFT, ST_REM_KEY, ST_SCAN_OLD, ST_SCAN_NEW,
		ST_EMIT_UP, ST_EMIT_DN, ST_NEXT_KEY, ST_SCAN_OWN, ST_EMIT_OWN, ST_FLUSH
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item
		logic tbl_write;
		logic tbl_clear;
		logic scan_clr;  // reset scan slot and best
		logic scan_step; // evaluate one slot
		logic use_new;   // scan with new mods, else held mods
		logic key_sel;   // 0: input key, 1: held key at index
		logic save_old;  // copy best into old
		logic idx_clr;
		logic idx_inc;
		logic push;
		logic shift;     // held[idx] <= held[idx+1]
		logic pop;
		logic commit_mods;
		logic pend_load; // capture slot of the pending result
		logic pend_old;  // 1: pending slot from old, 0: from best
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] action;
		logic is_mod;
		logic mods_change;
		logic scan_done;
		logic found;
		logic idx_match;  // held[idx] == key
		logic idx_end;    // idx == held_count
		logic shift_end;  // idx+1 >= held_count
		logic full;
		logic best_valid;
		logic old_valid;
		logic differ;
	} stat_t;
endpackage

// ===== design/hkm_if.sv =====
interface hkm_in_if;
	logic valid;
	logic ready;
	logic [1:0] action;
	logic [7:0] key_code;
	logic [7:0] key_modifier_bits;
	logic [3:0] slot_index;
	logic [7:0] slot_key;
	logic [7:0] slot_modifiers;
	logic slot_enable;
	modport source (output valid, action, key_code, key_modifier_bits, slot_index,
		slot_key, slot_modifiers, slot_enable, input ready);
	modport sink (input valid, action, key_code, key_modifier_bits, slot_index,
		slot_key, slot_modifiers, slot_enable, output ready);
endinterface

interface hkm_out_if;
	logic valid;
	logic ready;
	logic [3:0] trigger_slot;
	logic went_down;
	logic last;
	modport source (output valid, trigger_slot, went_down, last, input ready);
	modport sink (input valid, trigger_slot, went_down, last, output ready);
endinterface

// ===== design/hkm_datapath.sv =====
module hkm_datapath (
	input  logic clk,
	input  logic arst_n,
	input  hkm_pkg::cmd_t cmd,
	output hkm_pkg::stat_t stat,
	input  logic [1:0] in_action,
	input  logic [7:0] in_key,
	input  logic [7:0] in_kmod,
	input  logic [3:0] in_sidx,
	input  logic [7:0] in_skey,
	input  logic [7:0] in_smod,
	input  logic in_sen,
	output logic [3:0] out_slot
);
	import hkm_pkg::*;

	logic [TRIGGER_SLOTS-1:0] valid_q;
	logic [7:0] tkey_q [TRIGGER_SLOTS];
	logic [7:0] tmod_q [TRIGGER_SLOTS];
	logic [7:0] held_q [HELD_KEYS];
	logic [CNT_W-1:0] count_q;
	logic [7:0] mods_q;
	logic [1:0] act_q;
	logic [7:0] key_q, kmod_q;
	logic [CNT_W-1:0] idx_q;
	logic [SLOT_W:0] slot_q;
	logic best_v_q, old_v_q;
	logic [3:0] best_q, old_q, best_d_q;
	logic [3:0] pend_slot_q;

	logic [7:0] new_mods, scan_mods, scan_key, diff;
	logic [3:0] d;
	logic [SLOT_W-1:0] si;
	logic [HELD_W-1:0] idx_lo, idx_nx;
	logic cand;

	assign idx_lo = idx_q[HELD_W-1:0];
	assign idx_nx = idx_lo + 1'b1;
	assign new_mods = (act_q == ACT_PRESS) ? (mods_q | kmod_q) : (mods_q & ~kmod_q);
	assign scan_mods = cmd.use_new ? new_mods : mods_q;
	assign scan_key = cmd.key_sel ? held_q[idx_lo] : key_q;
	assign si = slot_q[SLOT_W-1:0];
	assign diff = tmod_q[si] ^ scan_mods;
	always_comb begin
		d = '0;
		for (int b = 0; b < 8; b++) d = d + {3'd0, diff[b]};
	end
	assign cand = valid_q[si] && (tkey_q[si] == scan_key) &&
		((tmod_q[si] & scan_mods) == tmod_q[si]);

	// table valid bits and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			mods_q <= '0;
			idx_q <= '0;
			slot_q <= '0;
			best_v_q <= 1'b0;
			old_v_q <= 1'b0;
		end else begin
			if (cmd.tbl_clear) valid_q <= '0;
			if (cmd.tbl_write) valid_q[in_sidx] <= in_sen;
			if (cmd.push) count_q <= count_q + 1'b1;
			if (cmd.pop) count_q <= count_q - 1'b1;
			if (cmd.commit_mods) mods_q <= new_mods;
			if (cmd.idx_clr) idx_q <= '0;
			else if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			if (cmd.scan_clr) begin
				slot_q <= '0;
				best_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				slot_q <= slot_q + 1'b1;
				if (cand && (!best_v_q || d < best_d_q)) best_v_q <= 1'b1;
			end
			if (cmd.save_old) old_v_q <= best_v_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			key_q <= in_key;
			kmod_q <= in_kmod;
		end
		if (cmd.tbl_write) begin
			tkey_q[in_sidx] <= in_skey;
			tmod_q[in_sidx] <= in_smod;
		end
		if (cmd.push) held_q[count_q[HELD_W-1:0]] <= key_q;
		if (cmd.shift) held_q[idx_lo] <= held_q[idx_nx];
		if (cmd.scan_step && cand && (!best_v_q || d < best_d_q)) begin
			best_q <= si;
			best_d_q <= d;
		end
		if (cmd.save_old) old_q <= best_q;
		if (cmd.pend_load) pend_slot_q <= cmd.pend_old ? old_q : best_q;
	end

	assign out_slot = pend_slot_q;
	assign stat.action = act_q;
	assign stat.is_mod = (kmod_q != 8'd0);
	assign stat.mods_change = (new_mods != mods_q);
	assign stat.scan_done = (slot_q == 5'(TRIGGER_SLOTS - 1)) && cmd.scan_step;
	assign stat.found = best_v_q;
	assign stat.idx_match = (held_q[idx_lo] == key_q);
	assign stat.idx_end = (idx_q == count_q);
	assign stat.shift_end = (idx_q + 4'd1 >= count_q);
	assign stat.full = (count_q == CNT_W'(HELD_KEYS));
	assign stat.best_valid = best_v_q;
	assign stat.old_valid = old_v_q;
	assign stat.differ = (best_v_q != old_v_q) || (best_v_q && best_q != old_q);
endmodule

// ===== design/hkm_ctrl.sv =====
module hkm_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic out_down,
	output logic out_last,
	output hkm_pkg::cmd_t cmd,
	input  hkm_pkg::stat_t stat
);
	import hkm_pkg::*;

	state_t state_q, state_d;
	logic pend_q, pend_d;  // a result is held back until it is known whether it is last
	logic pdown_q, pdown_d;

	// state and pending result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q <= 1'b0;
			pdown_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q <= pend_d;
			pdown_q <= pdown_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		out_down = pdown_q;
		out_last = 1'b0;
		pend_d = pend_q;
		pdown_d = pdown_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				if (in_valid) state_d = ST_FIND;
			end
			ST_FIND: begin
				if (stat.action == ACT_WRITE) begin
					state_d = ST_IDLE;
				end else if (stat.action == ACT_CLEAR) begin
					cmd.tbl_clear = 1'b1;
					state_d = ST_IDLE;
				end else if (stat.is_mod) begin
					cmd.idx_clr = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = stat.mods_change ?
						(stat.idx_end ? ST_SCAN_OWN : ST_SCAN_OLD) : ST_IDLE;
					if (stat.mods_change && stat.idx_end) cmd.commit_mods = 1'b1;
				end else if (stat.idx_end) begin
					cmd.scan_clr = 1'b1;
					if (stat.action == ACT_PRESS && !stat.full) begin
						cmd.push = 1'b1;
						cmd.idx_clr = 1'b1;
						state_d = ST_SCAN_OWN;
					end else begin
						state_d = ST_IDLE;
					end
				end else if (stat.idx_match) begin
					if (stat.action == ACT_PRESS) state_d = ST_IDLE;
					else state_d = ST_SHIFT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
				if (state_d == ST_IDLE) cmd.idx_clr = 1'b1;
			end
			ST_SHIFT: begin
				if (stat.shift_end) begin
					cmd.pop = 1'b1;
					cmd.idx_clr = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = ST_SCAN_OWN;
				end else begin
					cmd.shift = 1'b1;
					cmd.idx_inc = 1'b1;
				end
			end
			ST_SCAN_OLD: begin
				cmd.key_sel = 1'b1;
				cmd.scan_step = 1'b1;
				if (stat.scan_done) state_d = ST_REM_KEY;
			end
			ST_REM_KEY: begin
				cmd.save_old = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = ST_SCAN_NEW;
			end
			ST_SCAN_NEW: begin
				cmd.key_sel = 1'b1;
				cmd.use_new = 1'b1;
				cmd.scan_step = 1'b1;
				if (stat.scan_done) state_d = ST_EMIT_UP;
			end
			ST_EMIT_UP: begin
				// a new result pushes the held one out, never as last
				if (stat.differ && stat.old_valid) begin
					out_valid = pend_q;
					if (!pend_q || out_ready) begin
						cmd.pend_load = 1'b1;
						cmd.pend_old = 1'b1;
						pend_d = 1'b1;
						pdown_d = 1'b0;
						state_d = ST_EMIT_DN;
					end
				end else begin
					state_d = ST_EMIT_DN;
				end
			end
			ST_EMIT_DN: begin
				if (stat.differ && stat.best_valid) begin
					out_valid = pend_q;
					if (!pend_q || out_ready) begin
						cmd.pend_load = 1'b1;
						pend_d = 1'b1;
						pdown_d = 1'b1;
						state_d = ST_NEXT_KEY;
					end
				end else begin
					state_d = ST_NEXT_KEY;
				end
			end
			ST_NEXT_KEY: begin
				cmd.idx_inc = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = ST_SCAN_OLD;
				if (stat.shift_end) begin
					cmd.idx_clr = 1'b1;
					cmd.commit_mods = 1'b1;
					state_d = ST_SCAN_OWN;
				end
			end
			ST_SCAN_OWN: begin
				cmd.scan_step = 1'b1;
				if (stat.scan_done) state_d = ST_EMIT_OWN;
			end
			ST_EMIT_OWN: begin
				if (stat.best_valid) begin
					out_valid = pend_q;
					if (!pend_q || out_ready) begin
						cmd.pend_load = 1'b1;
						pend_d = 1'b1;
						pdown_d = (stat.action == ACT_PRESS);
						state_d = ST_FLUSH;
					end
				end else begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// the held result is the final one of this transaction
				if (pend_q) begin
					out_valid = 1'b1;
					out_last = 1'b1;
					if (out_ready) begin
						pend_d = 1'b0;
						state_d = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ===== design/hotkey_modifier_matcher_top.sv =====
// Sequential matcher: one input transaction at a time, one slot compared per cycle.
// Table write/clear: the item is accepted, decoded in ST_FIND, then ready again.
// Key press/release: list search, own scan, emit, flush. A modifier change first
// runs, per held key, an old scan, a new scan and the up and down emits.
// Each result is held one step so the final one can carry last, and waits until
// taken. Reset clears all slots, held keys and modifiers at once.
module hotkey_modifier_matcher_top (
	input logic clk,
	input logic arst_n,
	hkm_in_if.sink in_ch,
	hkm_out_if.source out_ch
);
	import hkm_pkg::*;

	cmd_t cmd;
	stat_t stat;
	logic [3:0] out_slot;
	logic down, lst;

	hkm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_down(down), .out_last(lst),
		.cmd(cmd), .stat(stat)
	);

	// a write lands in the table on the accepting edge
	cmd_t dp_cmd;
	always_comb begin
		dp_cmd = cmd;
		dp_cmd.tbl_write = in_ch.valid && in_ch.ready &&
			(in_ch.action == ACT_WRITE);
	end

	hkm_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(dp_cmd), .stat(stat),
		.in_action(in_ch.action), .in_key(in_ch.key_code),
		.in_kmod(in_ch.key_modifier_bits), .in_sidx(in_ch.slot_index),
		.in_skey(in_ch.slot_key), .in_smod(in_ch.slot_modifiers),
		.in_sen(in_ch.slot_enable),
		.out_slot(out_slot)
	);

	assign out_ch.trigger_slot = out_slot;
	assign out_ch.went_down = down;
	assign out_ch.last = lst;
endmodule
